// ----- sv/sde_pkg.sv -----
// Shared types, constants and tables for the split-band de-esser.
`timescale 1ns / 1ps
package sde_pkg;

  localparam int SampleBits      = 24;
  localparam int Guard           = 32 - SampleBits;
  localparam int ChannelsDefault = 2;
  localparam int CfgIdxBits      = 3;
  localparam int CfgDataBits     = 18;
  localparam int AttBits         = 11;

  localparam int DivSteps = 54;
  localparam int ExpSteps = 24;
  localparam int LogSteps = 16;

  localparam logic [37:0] TcNum            = 38'd242044063232;
  localparam logic signed [31:0] LpNum     = 32'sd152080770;
  localparam logic signed [31:0] CbPerLog2 = 32'sd39456604;
  localparam logic signed [31:0] Log2Ten   = 32'sd7133786;
  localparam logic [31:0] EnvFloor         = 32'd2147;
  localparam logic [30:0] OneQ30           = 31'h4000_0000;

  typedef struct packed {
    logic signed [SampleBits-1:0] left_sample;
    logic signed [SampleBits-1:0] right_sample;
  } in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] left_out;
    logic signed [SampleBits-1:0] right_out;
    logic [AttBits-1:0]           attenuation;
  } out_t;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_TARGET_FREQUENCY = 3'd0,
    REG_TARGET_THRESHOLD = 3'd1,
    REG_TARGET_REDUCTION = 3'd2,
    REG_ENABLE_REDUCTION = 3'd3,
    REG_SAMPLE_RATE      = 3'd4,
    REG_CHANNELS_IN_USE  = 3'd5
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_LOAD_TC,
    OP_DIV_LOAD_LC,
    OP_DIV_STEP,
    OP_EXP_LOAD,
    OP_EXP_STEP,
    OP_EXP_END,
    OP_SM_MUL,
    OP_SM_ADD,
    OP_LC_MUL,
    OP_HI,
    OP_LOG_LOAD,
    OP_NORM,
    OP_LOG_PREP,
    OP_LOG_STEP,
    OP_LOG_END,
    OP_LOG_MUL,
    OP_OVER,
    OP_TG_MUL,
    OP_OUT_MUL,
    OP_OUT_ADD,
    OP_ATT,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    TGT_FREQ,
    TGT_THR,
    TGT_RED,
    TGT_LP0,
    TGT_LP1,
    TGT_ENV,
    TGT_GAIN
  } tgt_e;

  typedef enum logic [2:0] {
    PH_TC,
    PH_LC,
    PH_TG,
    PH_ENV,
    PH_GAIN
  } phase_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TC_SETUP,
    ST_DIV,
    ST_EXP_LOAD,
    ST_EXP,
    ST_EXP_END,
    ST_SM_MUL,
    ST_SM_ADD,
    ST_LC_MUL,
    ST_LC_DIV,
    ST_HI,
    ST_LOG_LOAD,
    ST_NORM,
    ST_LOG_PREP,
    ST_LOG,
    ST_LOG_END,
    ST_LOG_MUL,
    ST_OVER,
    ST_TG_MUL,
    ST_OUT_MUL,
    ST_OUT_ADD,
    ST_ATT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] idx;
    tgt_e       tgt;
    logic       ch;
    logic [4:0] k;
    phase_e     phase;
  } cmd_t;

  typedef struct packed {
    logic norm_top;
    logic coef_ok;
    logic out_free;
    logic mono;
  } stat_t;

  function automatic logic [63:0] sde_isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    b   = 64'h4000_0000_0000_0000;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (b > rem) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (rem >= r + b) begin
          rem = rem - (r + b);
          r   = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [24:0][30:0] sde_pow_table();
    logic [24:0][30:0] tab;
    logic [63:0]       t;
    tab    = '0;
    t      = sde_isqrt(64'd1 << 59);
    tab[1] = t[30:0];
    for (int k = 2; k <= 24; k++) begin
      t      = sde_isqrt(t << 30);
      tab[k] = t[30:0];
    end
    return tab;
  endfunction

  localparam logic [24:0][30:0] PowTab = sde_pow_table();

endpackage

// ----- sv/sde_ctrl.sv -----
// Sequencer for the de-esser: steps the datapath through one frame.
`timescale 1ns / 1ps
module sde_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  sde_pkg::stat_t stat_i,
  output sde_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import sde_pkg::*;

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [2:0] idx_q, idx_d;
  phase_e     phase_q, phase_d;
  tgt_e       tgt_q, tgt_d;
  logic       ch_q, ch_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      phase_q <= PH_TC;
      tgt_q   <= TGT_FREQ;
      ch_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
      tgt_q   <= tgt_d;
      ch_q    <= ch_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    phase_d = phase_q;
    tgt_d   = tgt_q;
    ch_d    = ch_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.coef_ok) begin
            state_d = ST_SM_MUL;
            tgt_d   = TGT_FREQ;
          end else begin
            state_d = ST_TC_SETUP;
            idx_d   = '0;
          end
        end
      end
      ST_TC_SETUP: begin
        state_d = ST_DIV;
        cnt_d   = '0;
        phase_d = PH_TC;
      end
      ST_DIV: begin
        if (cnt_q == 6'(DivSteps - 1)) begin
          state_d = ST_EXP_LOAD;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_EXP_LOAD: begin
        state_d = ST_EXP;
        cnt_d   = '0;
      end
      ST_EXP: begin
        if (cnt_q == 6'(ExpSteps - 1)) begin
          state_d = ST_EXP_END;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_EXP_END: begin
        case (phase_q)
          PH_TC: begin
            if (idx_q == 3'd4) begin
              state_d = ST_SM_MUL;
              tgt_d   = TGT_FREQ;
            end else begin
              state_d = ST_TC_SETUP;
              idx_d   = idx_q + 3'd1;
            end
          end
          PH_LC: begin
            state_d = ST_SM_MUL;
            tgt_d   = TGT_LP0;
          end
          default: begin
            state_d = ST_SM_MUL;
            tgt_d   = TGT_GAIN;
          end
        endcase
      end
      ST_SM_MUL: state_d = ST_SM_ADD;
      ST_SM_ADD: begin
        case (tgt_q)
          TGT_FREQ: begin
            state_d = ST_SM_MUL;
            tgt_d   = TGT_THR;
          end
          TGT_THR: begin
            state_d = ST_SM_MUL;
            tgt_d   = TGT_RED;
          end
          TGT_RED: state_d = ST_LC_MUL;
          TGT_LP0: begin
            if (stat_i.mono) begin
              state_d = ST_HI;
            end else begin
              state_d = ST_SM_MUL;
              tgt_d   = TGT_LP1;
            end
          end
          TGT_LP1: state_d = ST_HI;
          TGT_ENV: begin
            state_d = ST_LOG_LOAD;
            phase_d = PH_ENV;
          end
          default: begin
            state_d = ST_OUT_MUL;
            ch_d    = 1'b0;
          end
        endcase
      end
      ST_LC_MUL: state_d = ST_LC_DIV;
      ST_LC_DIV: begin
        state_d = ST_DIV;
        cnt_d   = '0;
        phase_d = PH_LC;
      end
      ST_HI: begin
        state_d = ST_SM_MUL;
        tgt_d   = TGT_ENV;
      end
      ST_LOG_LOAD: state_d = ST_NORM;
      ST_NORM: begin
        if (stat_i.norm_top) state_d = ST_LOG_PREP;
      end
      ST_LOG_PREP: begin
        state_d = ST_LOG;
        cnt_d   = '0;
      end
      ST_LOG: begin
        if (cnt_q == 6'(LogSteps - 1)) begin
          state_d = ST_LOG_END;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_LOG_END: state_d = ST_LOG_MUL;
      ST_LOG_MUL: state_d = (phase_q == PH_ENV) ? ST_OVER : ST_ATT;
      ST_OVER:    state_d = ST_TG_MUL;
      ST_TG_MUL: begin
        state_d = ST_EXP_LOAD;
        phase_d = PH_TG;
      end
      ST_OUT_MUL: state_d = ST_OUT_ADD;
      ST_OUT_ADD: begin
        if (!ch_q) begin
          state_d = ST_OUT_MUL;
          ch_d    = 1'b1;
        end else begin
          state_d = ST_LOG_LOAD;
          phase_d = PH_GAIN;
        end
      end
      ST_ATT: state_d = ST_EMIT;
      ST_EMIT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = OP_NONE;
    cmd_o.idx   = idx_q;
    cmd_o.tgt   = tgt_q;
    cmd_o.ch    = ch_q;
    cmd_o.k     = cnt_q[4:0] + 5'd1;
    cmd_o.phase = phase_q;
    busy_o      = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE:     cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      ST_TC_SETUP: cmd_o.op = OP_DIV_LOAD_TC;
      ST_DIV:      cmd_o.op = OP_DIV_STEP;
      ST_EXP_LOAD: cmd_o.op = OP_EXP_LOAD;
      ST_EXP:      cmd_o.op = OP_EXP_STEP;
      ST_EXP_END:  cmd_o.op = OP_EXP_END;
      ST_SM_MUL:   cmd_o.op = OP_SM_MUL;
      ST_SM_ADD:   cmd_o.op = OP_SM_ADD;
      ST_LC_MUL:   cmd_o.op = OP_LC_MUL;
      ST_LC_DIV:   cmd_o.op = OP_DIV_LOAD_LC;
      ST_HI:       cmd_o.op = OP_HI;
      ST_LOG_LOAD: cmd_o.op = OP_LOG_LOAD;
      ST_NORM:     cmd_o.op = stat_i.norm_top ? OP_NONE : OP_NORM;
      ST_LOG_PREP: cmd_o.op = OP_LOG_PREP;
      ST_LOG:      cmd_o.op = OP_LOG_STEP;
      ST_LOG_END:  cmd_o.op = OP_LOG_END;
      ST_LOG_MUL:  cmd_o.op = OP_LOG_MUL;
      ST_OVER:     cmd_o.op = OP_OVER;
      ST_TG_MUL:   cmd_o.op = OP_TG_MUL;
      ST_OUT_MUL:  cmd_o.op = OP_OUT_MUL;
      ST_OUT_ADD:  cmd_o.op = OP_OUT_ADD;
      ST_ATT:      cmd_o.op = OP_ATT;
      ST_EMIT:     cmd_o.op = stat_i.out_free ? OP_EMIT : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- sv/sde_dp.sv -----
// Datapath for the de-esser: registers, shared multiplier, divider, exp and log units.
`timescale 1ns / 1ps
module sde_dp #(
  parameter int Channels = sde_pkg::ChannelsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sde_pkg::cmd_t                     cmd_i,
  output sde_pkg::stat_t                    stat_o,
  input  sde_pkg::in_t                      in_data_i,
  input  logic                              cfg_we_i,
  input  logic [sde_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [sde_pkg::CfgDataBits-1:0]   cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sde_pkg::out_t                     out_data_o
);
  import sde_pkg::*;

  localparam int OutW = 35 - Guard;
  localparam logic signed [OutW-1:0] SatMax = OutW'((64'sd1 <<< (SampleBits - 1)) - 1);
  localparam logic signed [OutW-1:0] SatMin = OutW'(-(64'sd1 <<< (SampleBits - 1)));

  logic [13:0] tf_q;
  logic [13:0] thr_q;
  logic [10:0] tr_q;
  logic        en_q;
  logic [17:0] fs_q;
  logic [1:0]  chn_q;

  logic [30:0] cp_q, da_q, dr_q, ga_q, gr_q, lc_q, tg_q;
  logic        coef_ok_q;

  logic signed [31:0] sf_q, st_q, sr_q;
  logic signed [31:0] lp_q [2];
  logic [31:0]        env_q;
  logic [30:0]        gain_q;

  logic signed [31:0] x_q [2];
  logic signed [32:0] hi_q [2];
  logic [31:0]        level_q;

  logic signed [67:0] mul_q;
  logic [27:0]        rem_q, den_q;
  logic [53:0]        quo_q;
  logic [30:0]        r_q;
  logic [23:0]        fr_q;
  logic [4:0]         n_q;
  logic               big_q;
  logic [31:0]        m_q;
  logic [4:0]         sh_q;
  logic [4:0]         p_q;
  logic [15:0]        frac_q;
  logic signed [22:0] logv_q;
  logic [31:0]        desired_q;

  logic signed [SampleBits-1:0] res_l_q, res_r_q;
  logic [AttBits-1:0]           res_att_q;
  logic                         out_valid_q;
  out_t                         out_q;

  logic               nch2;
  logic [17:0]        fs;
  logic signed [35:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [67:0] mul_p;
  logic signed [33:0] sm_s, sm_t;
  logic [30:0]        sm_c;
  logic signed [34:0] sm_diff, sm_sum;
  logic signed [31:0] one_minus_c;
  logic [9:0]         tenths;
  logic [28:0]        div_t;
  logic               div_ge;
  logic [53:0]        exp_y;
  logic [29:0]        exp_n;
  logic [30:0]        exp_res;
  logic [31:0]        log_src;
  logic [31:0]        log_t;
  logic signed [6:0]  pmf;
  logic signed [32:0] hi0, hi1;
  logic [31:0]        abs0, abs1;
  logic signed [35:0] lv, over;
  logic [37:0]        des3, desired_w, red_w;
  logic signed [39:0] av;
  logic signed [23:0] att_r;
  logic signed [34:0] o_sum;
  logic signed [OutW-1:0] o_sh;
  logic signed [SampleBits-1:0] o_sat;
  logic [31:0]        f_clamp;

  assign nch2 = (Channels >= 2) && (chn_q >= 2'd2);
  assign fs   = (fs_q == '0) ? 18'd1 : fs_q;

  always_comb begin
    case (cmd_i.tgt)
      TGT_FREQ: begin
        sm_s = 34'(sf_q);
        sm_t = $signed({4'b0, tf_q, 16'b0});
        sm_c = cp_q;
      end
      TGT_THR: begin
        sm_s = 34'(st_q);
        sm_t = $signed({{4{thr_q[13]}}, thr_q, 16'b0});
        sm_c = cp_q;
      end
      TGT_RED: begin
        sm_s = 34'(sr_q);
        sm_t = en_q ? $signed({7'b0, tr_q, 16'b0}) : '0;
        sm_c = cp_q;
      end
      TGT_LP0: begin
        sm_s = 34'(lp_q[0]);
        sm_t = 34'(x_q[0]);
        sm_c = lc_q;
      end
      TGT_LP1: begin
        sm_s = 34'(lp_q[1]);
        sm_t = 34'(x_q[1]);
        sm_c = lc_q;
      end
      TGT_ENV: begin
        sm_s = $signed({2'b0, env_q});
        sm_t = $signed({2'b0, level_q});
        sm_c = (level_q > env_q) ? da_q : dr_q;
      end
      default: begin
        sm_s = $signed({3'b0, gain_q});
        sm_t = $signed({3'b0, tg_q});
        sm_c = (tg_q < gain_q) ? ga_q : gr_q;
      end
    endcase
    sm_diff     = 35'(sm_t) - 35'(sm_s);
    one_minus_c = $signed({1'b0, OneQ30}) - $signed({1'b0, sm_c});
    sm_sum      = 35'(sm_s) + $signed(mul_q[64:30]);
  end

  assign f_clamp = sf_q[31] ? '0 : sf_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SM_MUL: begin
        mul_a = 36'(sm_diff);
        mul_b = one_minus_c;
      end
      OP_LC_MUL: begin
        mul_a = $signed({8'b0, f_clamp[31:4]});
        mul_b = LpNum;
      end
      OP_LOG_MUL: begin
        mul_a = (cmd_i.phase == PH_ENV) ? 36'(logv_q) : -36'(logv_q);
        mul_b = CbPerLog2;
      end
      OP_TG_MUL: begin
        mul_a = $signed({4'b0, desired_q});
        mul_b = Log2Ten;
      end
      OP_OUT_MUL: begin
        mul_a = 36'(hi_q[cmd_i.ch]);
        mul_b = $signed({1'b0, gain_q});
      end
      OP_EXP_STEP: begin
        mul_a = $signed({5'b0, r_q});
        mul_b = $signed({1'b0, PowTab[cmd_i.k]});
      end
      OP_LOG_STEP: begin
        mul_a = $signed({4'b0, m_q});
        mul_b = $signed(m_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (cmd_i.idx)
      3'd0:    tenths = 10'd450;
      3'd1:    tenths = 10'd15;
      3'd2:    tenths = 10'd650;
      3'd3:    tenths = 10'd20;
      default: tenths = 10'd900;
    endcase
    div_t  = {rem_q, quo_q[53]};
    div_ge = (div_t >= {1'b0, den_q});
  end

  always_comb begin
    case (cmd_i.phase)
      PH_TC:   exp_y = quo_q;
      PH_LC:   exp_y = quo_q >> 12;
      default: exp_y = {10'b0, mul_q[67:24]};
    endcase
    exp_n   = exp_y[53:24];
    exp_res = big_q ? '0 : (r_q >> n_q);
  end

  always_comb begin
    if (cmd_i.phase == PH_ENV) begin
      log_src = (env_q < EnvFloor) ? EnvFloor : env_q;
      pmf     = $signed({2'b0, p_q}) - 7'sd31;
    end else begin
      log_src = (gain_q == '0) ? 32'd1 : {1'b0, gain_q};
      pmf     = $signed({2'b0, p_q}) - 7'sd30;
    end
    log_t = mul_p[61:30];
  end

  always_comb begin
    hi0  = 33'(x_q[0]) - 33'(lp_q[0]);
    hi1  = 33'(x_q[1]) - 33'(lp_q[1]);
    abs0 = hi0[32] ? 32'(-hi0) : hi0[31:0];
    abs1 = hi1[32] ? 32'(-hi1) : hi1[31:0];
  end

  always_comb begin
    lv        = mul_q[51:16];
    over      = lv - 36'(st_q);
    des3      = over[35] ? '0 : ({2'b0, over} + {1'b0, over, 1'b0});
    red_w     = sr_q[31] ? '0 : {6'b0, sr_q};
    desired_w = ((des3 >> 2) > red_w) ? red_w : (des3 >> 2);
    av        = mul_q[55:16];
    att_r     = 24'((av + 40'sd32768) >>> 16);
  end

  always_comb begin
    o_sum = 35'(lp_q[cmd_i.ch]) + $signed(mul_q[64:30]);
    o_sh  = OutW'(o_sum >>> Guard);
    if (o_sh > SatMax) begin
      o_sat = SampleBits'(SatMax);
    end else if (o_sh < SatMin) begin
      o_sat = SampleBits'(SatMin);
    end else begin
      o_sat = SampleBits'(o_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tf_q        <= 14'd6000;
      thr_q       <= 14'(16384 - 2400);
      tr_q        <= 11'd600;
      en_q        <= 1'b1;
      fs_q        <= 18'd48000;
      chn_q       <= 2'd2;
      coef_ok_q   <= 1'b0;
      sf_q        <= 32'sd6000 <<< 16;
      st_q        <= -(32'sd2400 <<< 16);
      sr_q        <= 32'sd600 <<< 16;
      lp_q[0]     <= '0;
      lp_q[1]     <= '0;
      env_q       <= '0;
      gain_q      <= OneQ30;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_TARGET_FREQUENCY: tf_q  <= cfg_data_i[13:0];
          REG_TARGET_THRESHOLD: thr_q <= cfg_data_i[13:0];
          REG_TARGET_REDUCTION: tr_q  <= cfg_data_i[10:0];
          REG_ENABLE_REDUCTION: en_q  <= cfg_data_i[0];
          REG_SAMPLE_RATE: begin
            fs_q      <= cfg_data_i[17:0];
            coef_ok_q <= 1'b0;
          end
          REG_CHANNELS_IN_USE:  chn_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_EXP_END: begin
          if (cmd_i.phase == PH_TC && cmd_i.idx == 3'd4) coef_ok_q <= 1'b1;
        end
        OP_SM_ADD: begin
          case (cmd_i.tgt)
            TGT_FREQ: sf_q    <= sm_sum[31:0];
            TGT_THR:  st_q    <= sm_sum[31:0];
            TGT_RED:  sr_q    <= sm_sum[31:0];
            TGT_LP0:  lp_q[0] <= sm_sum[31:0];
            TGT_LP1:  lp_q[1] <= sm_sum[31:0];
            TGT_ENV:  env_q   <= sm_sum[31:0];
            default:  gain_q  <= sm_sum[30:0];
          endcase
        end
        OP_EMIT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x_q[0] <= $signed({in_data_i.left_sample, {Guard{1'b0}}});
        x_q[1] <= $signed({in_data_i.right_sample, {Guard{1'b0}}});
      end
      OP_DIV_LOAD_TC: begin
        rem_q <= '0;
        den_q <= 28'(tenths * fs);
        quo_q <= 54'(TcNum);
      end
      OP_DIV_LOAD_LC: begin
        rem_q <= '0;
        den_q <= 28'(fs);
        quo_q <= mul_q[53:0];
      end
      OP_DIV_STEP: begin
        rem_q <= div_ge ? 28'(div_t - {1'b0, den_q}) : div_t[27:0];
        quo_q <= {quo_q[52:0], div_ge};
      end
      OP_EXP_LOAD: begin
        big_q <= (exp_n >= 30'd31);
        n_q   <= exp_n[4:0];
        fr_q  <= exp_y[23:0];
        r_q   <= OneQ30;
      end
      OP_EXP_STEP: begin
        if (fr_q[23]) r_q <= mul_p[60:30];
        fr_q <= {fr_q[22:0], 1'b0};
      end
      OP_EXP_END: begin
        case (cmd_i.phase)
          PH_TC: begin
            case (cmd_i.idx)
              3'd0:    cp_q <= exp_res;
              3'd1:    da_q <= exp_res;
              3'd2:    dr_q <= exp_res;
              3'd3:    ga_q <= exp_res;
              default: gr_q <= exp_res;
            endcase
          end
          PH_LC:   lc_q <= exp_res;
          default: tg_q <= exp_res;
        endcase
      end
      OP_SM_MUL, OP_LC_MUL, OP_LOG_MUL, OP_TG_MUL, OP_OUT_MUL: mul_q <= mul_p;
      OP_HI: begin
        hi_q[0] <= hi0;
        hi_q[1] <= hi1;
        level_q <= (nch2 && abs1 > abs0) ? abs1 : abs0;
      end
      OP_LOG_LOAD: begin
        m_q  <= log_src;
        sh_q <= '0;
      end
      OP_NORM: begin
        m_q  <= {m_q[30:0], 1'b0};
        sh_q <= sh_q + 5'd1;
      end
      OP_LOG_PREP: begin
        m_q    <= {1'b0, m_q[31:1]};
        p_q    <= 5'd31 - sh_q;
        frac_q <= '0;
      end
      OP_LOG_STEP: begin
        m_q    <= log_t[31] ? {1'b0, log_t[31:1]} : log_t;
        frac_q <= {frac_q[14:0], log_t[31]};
      end
      OP_LOG_END: logv_q <= $signed({pmf, frac_q});
      OP_OVER:    desired_q <= desired_w[31:0];
      OP_OUT_ADD: begin
        if (!cmd_i.ch) begin
          res_l_q <= o_sat;
        end else begin
          res_r_q <= nch2 ? o_sat : '0;
        end
      end
      OP_ATT: begin
        if (att_r < 0) begin
          res_att_q <= '0;
        end else if (att_r > 24'sd2047) begin
          res_att_q <= '1;
        end else begin
          res_att_q <= att_r[AttBits-1:0];
        end
      end
      OP_EMIT: begin
        out_q.left_out    <= res_l_q;
        out_q.right_out   <= res_r_q;
        out_q.attenuation <= res_att_q;
      end
      default: ;
    endcase
  end

  assign stat_o.norm_top = m_q[31];
  assign stat_o.coef_ok  = coef_ok_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign stat_o.mono     = !nch2;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/split_band_de_esser.sv -----
// Frame time varies with the log unit's normalize shifts, the channel count and output stalls.
// A 54-step divider and two 24-step exp passes dominate the per-frame work.
// The first frame after reset or a sample_rate write first rebuilds the five time coefficients.
// One frame in flight; the next is taken while a finished result waits in the output register.
// Reset (async, active low) restores config registers, smoothing state and output valid; work registers are not reset.
`timescale 1ns / 1ps
module split_band_de_esser #(
  parameter int Channels = sde_pkg::ChannelsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sde_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sde_pkg::out_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sde_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [sde_pkg::CfgDataBits-1:0] cfg_data_i
);
  import sde_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic busy;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;

  sde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  sde_dp #(
    .Channels (Channels)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
